@@ hdl/usbmidi_pkg.sv @@
// shared types and constants for the usb midi descriptor scanner
package usbmidi_pkg;

  // descriptor type codes
  localparam logic [7:0] DESC_INTERFACE = 8'd4;
  localparam logic [7:0] DESC_ENDPOINT  = 8'd5;

  // interface class and subclass of a midi streaming interface
  localparam logic [7:0] CLASS_AUDIO   = 8'd1;
  localparam logic [7:0] SUBCLASS_MIDI = 8'h03;

  // minimum descriptor lengths that are decoded
  localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
  localparam logic [7:0] EP_MIN_LEN    = 8'd7;

  // endpoint direction bit and transfer type codes
  localparam int unsigned DIR_IN_BIT = 7;
  localparam logic [1:0]  XFER_BULK  = 2'd2;
  localparam logic [1:0]  XFER_INTR  = 2'd3;

  // byte offsets inside a descriptor
  localparam logic [7:0] OFF_LENGTH   = 8'd0;
  localparam logic [7:0] OFF_KIND     = 8'd1;
  localparam logic [7:0] OFF_IF_NUM   = 8'd2;
  localparam logic [7:0] OFF_IF_CLASS = 8'd5;
  localparam logic [7:0] OFF_IF_SUB   = 8'd6;
  localparam logic [7:0] OFF_EP_ADDR  = 8'd2;
  localparam logic [7:0] OFF_EP_ATTR  = 8'd3;
  localparam logic [7:0] OFF_MPS_LO   = 8'd4;
  localparam logic [7:0] OFF_MPS_HI   = 8'd5;

  // byte positions in the set that carry the total length, and byte count bounds
  localparam logic [15:0] TOTAL_LO_IDX  = 16'd2;
  localparam logic [15:0] TOTAL_HI_IDX  = 16'd3;
  localparam logic [15:0] MIN_END_COUNT = 16'd4;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // one scan result
  typedef struct packed {
    logic        found;
    logic [7:0]  in_endpoint;
    logic [7:0]  out_endpoint;
    logic [15:0] in_max_packet;
    logic [7:0]  interface_number;
    logic        interface_seen;
  } res_t;

endpackage

@@ hdl/usbmidi_parse.sv @@
// per-byte descriptor walker: parse state and held endpoint results
module usbmidi_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  output logic               res_valid,
  output usbmidi_pkg::res_t  res_data
);

  logic [15:0]       byte_count_r, byte_count_nxt;
  logic [15:0]       total_length_r, total_length_nxt;
  logic [7:0]        desc_offset_r, desc_offset_nxt;
  logic [7:0]        desc_length_r, desc_length_nxt;
  logic [7:0]        desc_kind_r, desc_kind_nxt;
  logic              parse_active_r, parse_active_nxt;
  logic              in_midi_r, in_midi_nxt;
  logic [7:0]        pend_class_r, pend_class_nxt;
  logic [7:0]        pend_field_r, pend_field_nxt;
  logic [1:0]        pend_xfer_r, pend_xfer_nxt;
  logic [7:0]        pend_mps_lo_r, pend_mps_lo_nxt;
  usbmidi_pkg::res_t held_r, held_nxt;

  // next parse state for one accepted byte
  always_comb begin : parse_step
    logic [7:0] off;
    off = '0;
    byte_count_nxt   = byte_count_r;
    total_length_nxt = total_length_r;
    desc_offset_nxt  = desc_offset_r;
    desc_length_nxt  = desc_length_r;
    desc_kind_nxt    = desc_kind_r;
    parse_active_nxt = parse_active_r;
    in_midi_nxt      = in_midi_r;
    pend_class_nxt   = pend_class_r;
    pend_field_nxt   = pend_field_r;
    pend_xfer_nxt    = pend_xfer_r;
    pend_mps_lo_nxt  = pend_mps_lo_r;
    held_nxt         = held_r;
    res_valid        = 1'b0;
    if (acc) begin
      // restart clears everything and treats this byte as byte 0
      if (first_byte) begin
        byte_count_nxt   = '0;
        total_length_nxt = '0;
        desc_offset_nxt  = '0;
        desc_length_nxt  = '0;
        desc_kind_nxt    = '0;
        in_midi_nxt      = 1'b0;
        pend_class_nxt   = '0;
        pend_field_nxt   = '0;
        pend_xfer_nxt    = '0;
        pend_mps_lo_nxt  = '0;
        held_nxt         = '0;
        parse_active_nxt = 1'b1;
      end
      if (parse_active_nxt) begin
        off = desc_offset_nxt;
        // total length capture
        if (byte_count_nxt == usbmidi_pkg::TOTAL_LO_IDX) begin
          total_length_nxt[7:0] = data_byte;
        end else if (byte_count_nxt == usbmidi_pkg::TOTAL_HI_IDX) begin
          total_length_nxt[15:8] = data_byte;
        end
        if (off == usbmidi_pkg::OFF_LENGTH && data_byte == 8'd0) begin
          // zero length byte ends the set
          res_valid        = 1'b1;
          parse_active_nxt = 1'b0;
        end else begin
          // field capture by offset
          if (off == usbmidi_pkg::OFF_LENGTH) begin
            desc_length_nxt = data_byte;
            desc_kind_nxt   = '0;
          end else if (off == usbmidi_pkg::OFF_KIND) begin
            desc_kind_nxt = data_byte;
          end else if (desc_kind_nxt == usbmidi_pkg::DESC_INTERFACE &&
                       desc_length_nxt >= usbmidi_pkg::IFACE_MIN_LEN) begin
            if (off == usbmidi_pkg::OFF_IF_NUM) begin
              pend_field_nxt = data_byte;
            end else if (off == usbmidi_pkg::OFF_IF_CLASS) begin
              pend_class_nxt = data_byte;
            end else if (off == usbmidi_pkg::OFF_IF_SUB) begin
              if (pend_class_nxt == usbmidi_pkg::CLASS_AUDIO &&
                  data_byte == usbmidi_pkg::SUBCLASS_MIDI) begin
                in_midi_nxt               = 1'b1;
                held_nxt.interface_number = pend_field_nxt;
                held_nxt.interface_seen   = 1'b1;
              end else begin
                in_midi_nxt = 1'b0;
              end
            end
          end else if (desc_kind_nxt == usbmidi_pkg::DESC_ENDPOINT &&
                       desc_length_nxt >= usbmidi_pkg::EP_MIN_LEN && in_midi_nxt) begin
            if (off == usbmidi_pkg::OFF_EP_ADDR) begin
              pend_field_nxt = data_byte;
            end else if (off == usbmidi_pkg::OFF_EP_ATTR) begin
              pend_xfer_nxt   = data_byte[1:0];
              pend_mps_lo_nxt = '0;
            end else if (off == usbmidi_pkg::OFF_MPS_LO) begin
              pend_mps_lo_nxt = data_byte;
            end else if (off == usbmidi_pkg::OFF_MPS_HI) begin
              if (pend_xfer_nxt == usbmidi_pkg::XFER_BULK ||
                  pend_xfer_nxt == usbmidi_pkg::XFER_INTR) begin
                if (pend_field_nxt[usbmidi_pkg::DIR_IN_BIT]) begin
                  held_nxt.in_endpoint   = pend_field_nxt;
                  held_nxt.found         = (pend_field_nxt != 8'd0);
                  held_nxt.in_max_packet = {data_byte, pend_mps_lo_nxt};
                end else begin
                  held_nxt.out_endpoint = pend_field_nxt;
                end
              end
            end
          end
          // advance within the descriptor
          if ({1'b0, off} + 9'd1 >= {1'b0, desc_length_nxt}) begin
            desc_offset_nxt = '0;
          end else begin
            desc_offset_nxt = off + 8'd1;
          end
          // saturating byte count
          if (byte_count_nxt != usbmidi_pkg::COUNT_MAX) begin
            byte_count_nxt = byte_count_nxt + 16'd1;
          end
          // end of set by total length
          if (byte_count_nxt >= usbmidi_pkg::MIN_END_COUNT &&
              byte_count_nxt >= total_length_nxt) begin
            res_valid        = 1'b1;
            parse_active_nxt = 1'b0;
          end
        end
      end
    end
  end

  assign res_data = held_nxt;

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      total_length_r <= '0;
      desc_offset_r  <= '0;
      desc_length_r  <= '0;
      desc_kind_r    <= '0;
      parse_active_r <= 1'b0;
      in_midi_r      <= 1'b0;
      pend_class_r   <= '0;
      pend_field_r   <= '0;
      pend_xfer_r    <= '0;
      pend_mps_lo_r  <= '0;
      held_r         <= '0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      total_length_r <= total_length_nxt;
      desc_offset_r  <= desc_offset_nxt;
      desc_length_r  <= desc_length_nxt;
      desc_kind_r    <= desc_kind_nxt;
      parse_active_r <= parse_active_nxt;
      in_midi_r      <= in_midi_nxt;
      pend_class_r   <= pend_class_nxt;
      pend_field_r   <= pend_field_nxt;
      pend_xfer_r    <= pend_xfer_nxt;
      pend_mps_lo_r  <= pend_mps_lo_nxt;
      held_r         <= held_nxt;
    end
  end

endmodule

@@ hdl/usbmidi_outq.sv @@
// result register with one skid entry so input stays open during a stall until the skid entry fills
module usbmidi_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  usbmidi_pkg::res_t  push_data,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output usbmidi_pkg::res_t  out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  usbmidi_pkg::res_t out_data_r, out_data_nxt;
  usbmidi_pkg::res_t skid_data_r, skid_data_nxt;
  logic              out_free;

  assign out_free   = !out_valid_r || out_ready;
  assign push_ready = !skid_valid_r;

  // refill output from skid first, then from a new result
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/usb_midi_descriptor_scanner.sv @@
// top level of the usb midi descriptor scanner
//
// Input channel: one byte of a usb configuration descriptor set per transfer
// (in_data_byte), with in_first_byte marking byte 0 of a new set. Output
// channel: one result per finished set (endpoint addresses, max packet size,
// midi streaming interface number and flags).
// Each byte is handled in the cycle of its transfer; the parse state is kept
// in registers, so a byte can be taken every cycle while in_ready is high.
// A set ends on a zero length byte at a descriptor start or when the byte
// count reaches the total length; its result is registered in the output
// register, or in the skid entry while the receiver stalls.
// Output is a result register backed by one skid entry: while the receiver
// stalls, bytes keep flowing until a second result is waiting, and only then
// does in_ready drop. in_ready is driven from a register.
// Synchronous active-low reset clears the parse state and empties the output;
// bytes without in_first_byte while no set is open are dropped silently.
module usb_midi_descriptor_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [7:0]  out_in_endpoint,
  output logic [7:0]  out_out_endpoint,
  output logic [15:0] out_in_max_packet,
  output logic [7:0]  out_interface_number,
  output logic        out_interface_seen
);

  logic              in_acc;
  logic              res_valid;
  usbmidi_pkg::res_t res_data;
  usbmidi_pkg::res_t out_data;

  assign in_acc = in_valid && in_ready;

  // descriptor walker
  usbmidi_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .data_byte  (in_data_byte),
    .first_byte (in_first_byte),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  // result output stage
  usbmidi_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res_data),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_found            = out_data.found;
  assign out_in_endpoint      = out_data.in_endpoint;
  assign out_out_endpoint     = out_data.out_endpoint;
  assign out_in_max_packet    = out_data.in_max_packet;
  assign out_interface_number = out_data.interface_number;
  assign out_interface_seen   = out_data.interface_seen;

endmodule

@@ hdl/usbmidi_checker.sv @@
// port-level checks for the usb midi descriptor scanner
module usbmidi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_first_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [7:0]  out_in_endpoint,
  input logic [7:0]  out_out_endpoint,
  input logic [15:0] out_in_max_packet,
  input logic [7:0]  out_interface_number,
  input logic        out_interface_seen
);

  // a stalled result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // found flag agrees with the in endpoint address
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found == (out_in_endpoint != 8'd0)))
    else $error("found flag does not match in endpoint");

  // a reported in endpoint carries the direction bit
  a_in_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_in_endpoint[7])
    else $error("in endpoint without direction bit");

  // no interface number without a midi streaming interface
  a_iface: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_interface_seen |-> (out_interface_number == 8'd0))
    else $error("interface number set with no interface seen");

  // input closes only after the receiver stalled a result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input closed without an output stall");

endmodule

bind usb_midi_descriptor_scanner usbmidi_checker u_usbmidi_checker (.*);
